// ===== sv/dtse_pkg.sv =====
package dtse_pkg;

    typedef enum logic [1:0] {
        ACT_INC  = 2'd0,
        ACT_DEC  = 2'd1,
        ACT_SET  = 2'd2,
        ACT_LOAD = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_YEAR    = 3'd1,
        POS_MONTH   = 3'd2,
        POS_DAY     = 3'd3,
        POS_HOUR    = 3'd4,
        POS_MINUTE  = 3'd5,
        POS_WEEKDAY = 3'd6
    } t_pos;

    localparam logic [6:0] YEAR_MIN    = 7'd0;
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [6:0] MONTH_MIN   = 7'd1;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] DAY_MIN     = 7'd1;
    localparam logic [6:0] HOUR_MIN    = 7'd0;
    localparam logic [6:0] HOUR_MAX    = 7'd23;
    localparam logic [6:0] MINUTE_MIN  = 7'd0;
    localparam logic [6:0] MINUTE_MAX  = 7'd59;
    localparam logic [6:0] WEEKDAY_MIN = 7'd1;
    localparam logic [6:0] WEEKDAY_MAX = 7'd7;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    typedef struct packed {
        t_pos       pos;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
    } t_state;

    localparam t_state STATE_RESET = '{
        pos:     POS_IDLE,
        year:    7'd0,
        month:   4'd1,
        day:     5'd1,
        hour:    5'd0,
        minute:  6'd0,
        weekday: 3'd1
    };

    typedef struct packed {
        logic [2:0] edit_position;
        logic [6:0] year_now;
        logic [3:0] month_now;
        logic [4:0] day_now;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [2:0] weekday_now;
        logic [4:0] month_length;
        logic       commit;
    } t_result;

    function automatic logic [4:0] f_month_length(input logic [3:0] month,
                                                  input logic [6:0] year);
        logic [4:0] len;
        len = 5'd31;
        if (month == MONTH_FEB) begin
            len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

    // wrap on inc/dec, clamp on set
    function automatic logic [6:0] f_adjust(input logic [6:0] value,
                                            input logic [6:0] lo,
                                            input logic [6:0] hi,
                                            input t_action    act);
        logic [7:0] up;
        logic [6:0] res;
        up  = {1'b0, value} + 8'd1;
        res = value;
        case (act)
            ACT_INC: res = (up > {1'b0, hi}) ? lo : up[6:0];
            ACT_DEC: res = (value == 7'd0 || value <= lo) ? hi : value - 7'd1;
            ACT_SET: res = (value > hi) ? hi : value;
            default: res = value;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/dtse_update.sv =====
module dtse_update
    import dtse_pkg::*;
(
    input  t_state     i_state,
    input  t_action    i_action,
    input  logic [6:0] i_load_year,
    input  logic [3:0] i_load_month,
    input  logic [4:0] i_load_day,
    input  logic [4:0] i_load_hour,
    input  logic [5:0] i_load_minute,
    input  logic [2:0] i_load_weekday,
    output t_state     o_state,
    output t_result    o_result
);

    logic [6:0] value;
    logic [6:0] lo;
    logic [6:0] hi;
    logic [6:0] adj;
    logic       commit;
    t_state     nxt;

    always_comb begin
        case (i_state.pos)
            POS_IDLE: begin
                value = 7'd0;
                lo    = 7'd0;
                hi    = 7'd0;
            end
            POS_YEAR: begin
                value = i_state.year;
                lo    = YEAR_MIN;
                hi    = YEAR_MAX;
            end
            POS_MONTH: begin
                value = {3'b000, i_state.month};
                lo    = MONTH_MIN;
                hi    = MONTH_MAX;
            end
            POS_DAY: begin
                value = {2'b00, i_state.day};
                lo    = DAY_MIN;
                hi    = {2'b00, f_month_length(i_state.month, i_state.year)};
            end
            POS_HOUR: begin
                value = {2'b00, i_state.hour};
                lo    = HOUR_MIN;
                hi    = HOUR_MAX;
            end
            POS_MINUTE: begin
                value = {1'b0, i_state.minute};
                lo    = MINUTE_MIN;
                hi    = MINUTE_MAX;
            end
            default: begin
                value = {4'b0000, i_state.weekday};
                lo    = WEEKDAY_MIN;
                hi    = WEEKDAY_MAX;
            end
        endcase
    end

    assign adj = f_adjust(value, lo, hi, i_action);

    always_comb begin
        nxt    = i_state;
        commit = 1'b0;
        if (i_state.pos == POS_IDLE) begin
            if (i_action == ACT_SET) begin
                nxt.pos = POS_YEAR;
            end else if (i_action == ACT_LOAD) begin
                nxt.year    = i_load_year;
                nxt.month   = i_load_month;
                nxt.day     = i_load_day;
                nxt.hour    = i_load_hour;
                nxt.minute  = i_load_minute;
                nxt.weekday = i_load_weekday;
            end
        end else if (i_action != ACT_LOAD) begin
            case (i_state.pos)
                POS_YEAR:   nxt.year    = adj;
                POS_MONTH:  nxt.month   = adj[3:0];
                POS_DAY:    nxt.day     = adj[4:0];
                POS_HOUR:   nxt.hour    = adj[4:0];
                POS_MINUTE: nxt.minute  = adj[5:0];
                default:    nxt.weekday = adj[2:0];
            endcase
            if (i_action == ACT_SET) begin
                if (i_state.pos >= POS_WEEKDAY) begin
                    nxt.pos = POS_IDLE;
                    commit  = 1'b1;
                end else begin
                    nxt.pos = t_pos'(3'(i_state.pos) + 3'd1);
                end
            end
        end
    end

    assign o_state = nxt;

    always_comb begin
        o_result.edit_position = 3'(nxt.pos);
        o_result.year_now      = nxt.year;
        o_result.month_now     = nxt.month;
        o_result.day_now       = nxt.day;
        o_result.hour_now      = nxt.hour;
        o_result.minute_now    = nxt.minute;
        o_result.weekday_now   = nxt.weekday;
        o_result.month_length  = f_month_length(nxt.month, nxt.year);
        o_result.commit        = commit;
    end

endmodule

// ===== sv/dtse_skid.sv =====
module dtse_skid
    import dtse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    push;
    logic    pop;
    logic    out_free;

    assign o_ready  = !r_skid_valid;
    assign push     = i_valid && !r_skid_valid;
    assign pop      = r_out_valid && i_ready;
    assign out_free = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (push) begin
                r_out <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat held with empty output register");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !pop) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid beat lost");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("output beat changed while stalled");

endmodule

// ===== sv/date_time_setting_editor.sv =====
// A result beat is registered in the output register, or held in the skid register while the output stalls.
// Throughput: one beat per cycle while o_ready is high; state update is a
// single compare-and-wrap step between state registers and output register.
// A two-entry output stage keeps input ready while one result waits.
// Reset (synchronous, active low): idle, 00-01-01 00:00, weekday 1, no beats.
module date_time_setting_editor
    import dtse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [6:0] i_load_year,
    input  logic [3:0] i_load_month,
    input  logic [4:0] i_load_day,
    input  logic [4:0] i_load_hour,
    input  logic [5:0] i_load_minute,
    input  logic [2:0] i_load_weekday,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_edit_position,
    output logic [6:0] o_year_now,
    output logic [3:0] o_month_now,
    output logic [4:0] o_day_now,
    output logic [4:0] o_hour_now,
    output logic [5:0] o_minute_now,
    output logic [2:0] o_weekday_now,
    output logic [4:0] o_month_length,
    output logic       o_commit
);

    t_state  r_state;
    t_state  n_state;
    t_result result;
    t_result out_data;
    logic    accept;

    assign accept = i_valid && o_ready;

    dtse_update u_update (
        .i_state        (r_state),
        .i_action       (t_action'(i_action)),
        .i_load_year    (i_load_year),
        .i_load_month   (i_load_month),
        .i_load_day     (i_load_day),
        .i_load_hour    (i_load_hour),
        .i_load_minute  (i_load_minute),
        .i_load_weekday (i_load_weekday),
        .o_state        (n_state),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    dtse_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (result),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_edit_position = out_data.edit_position;
    assign o_year_now      = out_data.year_now;
    assign o_month_now     = out_data.month_now;
    assign o_day_now       = out_data.day_now;
    assign o_hour_now      = out_data.hour_now;
    assign o_minute_now    = out_data.minute_now;
    assign o_weekday_now   = out_data.weekday_now;
    assign o_month_length  = out_data.month_length;
    assign o_commit        = out_data.commit;

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_state))
        else $error("state changed without an input beat");

    a_idle_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state.pos == POS_IDLE &&
         (i_action == ACT_INC || i_action == ACT_DEC)) |=> $stable(r_state))
        else $error("inc/dec changed state while idle");

    a_commit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_state.pos == POS_WEEKDAY && i_action == ACT_SET)
            |=> (r_state.pos == POS_IDLE))
        else $error("set on weekday did not finish editing");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_commit) |-> (o_edit_position == 3'(POS_IDLE)))
        else $error("commit beat without idle position");

endmodule
